>>> rtl/dscv_pkg.sv
// ----------------------------------------------------------------------------
// dscv_pkg
// Shared types, constants and the sine table helper for the daylight
// spectrum curve block.
// ----------------------------------------------------------------------------
package dscv_pkg;

  localparam int SINE_TABLE_DEPTH = 256;
  localparam int FRACTION_BITS    = 16;

  localparam int MINUTE_W  = 11;
  localparam int FRAC_W    = 16;
  localparam int SHARE_W   = 17;   // normalized share, may reach 1.0
  localparam int CFG_IDX_W = 3;
  localparam int LANES     = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SUNRISE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUNSET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIMMING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RED     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_RED = 3'd7;

  // reset values
  localparam logic [MINUTE_W-1:0] RST_SUNRISE = 11'd360;
  localparam logic [MINUTE_W-1:0] RST_SUNSET  = 11'd1080;
  localparam logic [FRAC_W-1:0]   RST_PEAK    = 16'd52428;
  localparam logic [FRAC_W-1:0]   RST_DIMMING = 16'd65535;
  localparam logic [FRAC_W-1:0]   RST_WHITE   = 16'd26214;
  localparam logic [FRAC_W-1:0]   RST_BLUE    = 16'd13107;
  localparam logic [FRAC_W-1:0]   RST_RED     = 16'd19661;
  localparam logic [FRAC_W-1:0]   RST_FAR_RED = 16'd6554;

  // midday-biased mix: base and slope per channel (Q0.16)
  localparam logic [FRAC_W-1:0] MIX_BASE [LANES] = '{16'd19661, 16'd5243, 16'd28836, 16'd11796};
  localparam logic [FRAC_W-1:0] MIX_SLOPE [LANES] = '{16'd19661, 16'd14418, 16'd13107, 16'd7864};
  // channels whose mix falls with the dome
  localparam logic [LANES-1:0] MIX_FALLS = 4'b1100;

  localparam logic [FRAC_W-1:0] BLEND_MIX = 16'd45875;   // 0.7
  localparam logic [FRAC_W-1:0] BLEND_CFG = 16'd19661;   // 0.3

  // sum of shares at or below this counts as zero
  localparam logic [FRAC_W+1:0] SHARE_SUM_MIN = 18'd6;
  localparam logic [SHARE_W-1:0] FALLBACK_SHARE [LANES] =
    '{17'd26214, 17'd13107, 17'd19661, 17'd6554};

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef logic [SHARE_W-1:0] share_t;

  typedef struct packed {
    logic                daylight;
    logic [MINUTE_W-1:0] offset;
    logic [MINUTE_W-1:0] span;
  } slot_t;

  typedef struct packed {
    logic              daylight;
    logic [FRAC_W-1:0] dome;
    logic [FRAC_W-1:0] brightness;
    logic [FRAC_W-1:0] white;
    logic [FRAC_W-1:0] blue;
    logic [FRAC_W-1:0] red;
    logic [FRAC_W-1:0] far_red;
  } result_t;

  // sin(x) for x in Q2.30, Taylor series to x^13, result Q0.16 saturated
  function automatic logic [15:0] sine_q16(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] q;
    x2 = (x * x) >> 30;
    t  = x;
    s  = x;
    t = ((t * x2) >> 30) / 64'd6;   s = (s > t) ? s - t : 64'd0;
    t = ((t * x2) >> 30) / 64'd20;  s = s + t;
    t = ((t * x2) >> 30) / 64'd42;  s = (s > t) ? s - t : 64'd0;
    t = ((t * x2) >> 30) / 64'd72;  s = s + t;
    t = ((t * x2) >> 30) / 64'd110; s = (s > t) ? s - t : 64'd0;
    t = ((t * x2) >> 30) / 64'd156; s = s + t;
    q = (s + 64'd8192) >> 14;
    return (q > 64'd65535) ? 16'hFFFF : q[15:0];
  endfunction

endpackage

>>> rtl/daylight_spectrum_curve_top.sv
// ----------------------------------------------------------------------------
// daylight_spectrum_curve_top
// Minute-of-day to daylight dome, brightness and four channel levels.
// ----------------------------------------------------------------------------
// Push one minute word a cycle while full is low; results come out in order
// through a two-word output queue. Sustained rate is one word per cycle while
// results are popped and no share normalization runs. A word passes through
// the front register, the slot queue, FRACTION_BITS + 1 progress divide
// stages, five dome/brightness/blend stages, 17 channel share divide stages,
// the output register and the result queue. A full result queue stalls the
// whole back pipeline. After reset and after every configuration write, full
// stays high while a bit-serial divider normalizes the four configured shares;
// configuration writes are always taken.
module daylight_spectrum_curve_top #(
  parameter int SINE_TABLE_DEPTH = dscv_pkg::SINE_TABLE_DEPTH,
  parameter int FRACTION_BITS    = dscv_pkg::FRACTION_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [dscv_pkg::MINUTE_W-1:0]  minute_of_day,
  output logic                           empty,
  input  logic                           pop,
  output logic                           daylight,
  output logic [dscv_pkg::FRAC_W-1:0]    dome_level,
  output logic [dscv_pkg::FRAC_W-1:0]    brightness,
  output logic [dscv_pkg::FRAC_W-1:0]    white_level,
  output logic [dscv_pkg::FRAC_W-1:0]    blue_level,
  output logic [dscv_pkg::FRAC_W-1:0]    red_level,
  output logic [dscv_pkg::FRAC_W-1:0]    far_red_level,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dscv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dscv_pkg::FRAC_W-1:0]    cfg_data
);

  localparam int SLOT_W = $bits(dscv_pkg::slot_t);
  localparam int RES_W  = $bits(dscv_pkg::result_t);

  logic [dscv_pkg::MINUTE_W-1:0] sunrise;
  logic [dscv_pkg::MINUTE_W-1:0] sunset;
  logic [dscv_pkg::FRAC_W-1:0]   peak;
  logic [dscv_pkg::FRAC_W-1:0]   dimming;
  logic [dscv_pkg::FRAC_W-1:0]   shares [dscv_pkg::LANES];
  logic                          cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sunrise   <= dscv_pkg::RST_SUNRISE;
      sunset    <= dscv_pkg::RST_SUNSET;
      peak      <= dscv_pkg::RST_PEAK;
      dimming   <= dscv_pkg::RST_DIMMING;
      shares[0] <= dscv_pkg::RST_WHITE;
      shares[1] <= dscv_pkg::RST_BLUE;
      shares[2] <= dscv_pkg::RST_RED;
      shares[3] <= dscv_pkg::RST_FAR_RED;
    end else if (cfg_wr) begin
      case (cfg_index)
        dscv_pkg::REG_SUNRISE: sunrise   <= cfg_data[dscv_pkg::MINUTE_W-1:0];
        dscv_pkg::REG_SUNSET:  sunset    <= cfg_data[dscv_pkg::MINUTE_W-1:0];
        dscv_pkg::REG_PEAK:    peak      <= cfg_data;
        dscv_pkg::REG_DIMMING: dimming   <= cfg_data;
        dscv_pkg::REG_WHITE:   shares[0] <= cfg_data;
        dscv_pkg::REG_BLUE:    shares[1] <= cfg_data;
        dscv_pkg::REG_RED:     shares[2] <= cfg_data;
        dscv_pkg::REG_FAR_RED: shares[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // share normalization
  logic             norm_busy;
  dscv_pkg::share_t cfg_share [dscv_pkg::LANES];

  dscv_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .start    (cfg_wr),
    .shares   (shares),
    .busy     (norm_busy),
    .cfg_share(cfg_share)
  );

  // front stage
  logic            slot_push;
  logic            slot_full;
  logic            slot_valid;
  logic            slot_pop;
  dscv_pkg::slot_t slot_in;
  dscv_pkg::slot_t slot_out;

  dscv_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .minute_of_day(minute_of_day),
    .sunrise      (sunrise),
    .sunset       (sunset),
    .hold         (norm_busy),
    .slot_full    (slot_full),
    .full         (full),
    .slot_push    (slot_push),
    .slot         (slot_in)
  );

  dscv_queue #(.W(SLOT_W)) u_slot_q (
    .clk      (clk),
    .rst      (rst),
    .push     (slot_push),
    .push_data(slot_in),
    .pop      (slot_pop),
    .full     (slot_full),
    .valid    (slot_valid),
    .head     (slot_out)
  );

  // back pipeline stalls only when the result queue cannot take a word
  logic              res_full;
  logic              res_valid;
  logic              back_valid;
  logic              adv;
  dscv_pkg::result_t back_res;
  dscv_pkg::result_t head_res;

  assign adv = !res_full || pop;

  dscv_back #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (slot_valid),
    .in_slot  (slot_out),
    .peak     (peak),
    .dimming  (dimming),
    .cfg_share(cfg_share),
    .in_pop   (slot_pop),
    .out_valid(back_valid),
    .out_res  (back_res)
  );

  dscv_queue #(.W(RES_W)) u_res_q (
    .clk      (clk),
    .rst      (rst),
    .push     (back_valid && adv),
    .push_data(back_res),
    .pop      (pop),
    .full     (res_full),
    .valid    (res_valid),
    .head     (head_res)
  );

  assign empty         = !res_valid;
  assign daylight      = head_res.daylight;
  assign dome_level    = head_res.dome;
  assign brightness    = head_res.brightness;
  assign white_level   = head_res.white;
  assign blue_level    = head_res.blue;
  assign red_level     = head_res.red;
  assign far_red_level = head_res.far_red;

endmodule

>>> rtl/dscv_queue.sv
// ----------------------------------------------------------------------------
// dscv_queue
// Two-entry word queue with push and pop in the same cycle.
// ----------------------------------------------------------------------------
module dscv_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         full,
  output logic         valid,
  output logic [W-1:0] head
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign head    = mem[rd_ptr];
  assign do_pop  = pop && valid;
  assign do_push = push && (!full || do_pop);

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // store word
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule

>>> rtl/dscv_div.sv
// ----------------------------------------------------------------------------
// dscv_div
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module dscv_div #(
  parameter int LANES = 1,
  parameter int DW    = 27,
  parameter int VW    = 11,
  parameter int QW    = 17,
  parameter int SW    = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] dividend [LANES],
  input  logic [VW-1:0] divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] quotient [LANES],
  output logic [SW-1:0] out_side
);

  logic [VW-1:0] rem [QW][LANES];
  logic [QW-1:0] low [QW][LANES];
  logic [QW-1:0] quo [QW+1][LANES];
  logic [VW-1:0] dv  [QW];
  logic [SW-1:0] sd  [QW+1];
  logic          vl  [QW+1];

  // stage zero: split the dividend
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem[0][l] = VW'(dividend[l] >> QW);
      low[0][l] = dividend[l][QW-1:0];
      quo[0][l] = '0;
    end
  end
  assign dv[0] = divisor;
  assign sd[0] = in_side;
  assign vl[0] = in_valid;

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    logic [VW:0]   trial [LANES];
    logic [VW:0]   diff  [LANES];
    logic          ge    [LANES];

    // trial subtract
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {rem[s-1][l], low[s-1][l][QW-1]};
        diff[l]  = trial[l] - {1'b0, dv[s-1]};
        ge[l]    = (trial[l] >= {1'b0, dv[s-1]});
      end
    end

    // hold quotient and sideband
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          quo[s][l] <= {quo[s-1][l][QW-2:0], ge[l]};
        end
        sd[s] <= sd[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[s] <= 1'b0;
      end else if (en) begin
        vl[s] <= vl[s-1];
      end
    end

    if (s < QW) begin : g_mid
      always_ff @(posedge clk) begin
        if (en) begin
          for (int l = 0; l < LANES; l++) begin
            rem[s][l] <= ge[l] ? diff[l][VW-1:0] : trial[l][VW-1:0];
            low[s][l] <= low[s-1][l] << 1;
          end
          dv[s] <= dv[s-1];
        end
      end
    end
  end

  assign out_valid = vl[QW];
  assign out_side  = sd[QW];
  assign quotient  = quo[QW];

endmodule

>>> rtl/dscv_norm.sv
// ----------------------------------------------------------------------------
// dscv_norm
// Normalizes the four configured channel shares by their sum with one
// shared bit-serial divider, and falls back to fixed shares near zero.
// ----------------------------------------------------------------------------
module dscv_norm (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dscv_pkg::FRAC_W-1:0] shares [dscv_pkg::LANES],
  output logic                        busy,
  output dscv_pkg::share_t            cfg_share [dscv_pkg::LANES]
);

  localparam int SW = dscv_pkg::SHARE_W;
  localparam int VW = dscv_pkg::FRAC_W + 2;
  localparam int CW = $clog2(SW);

  logic [VW-1:0]    sum;
  logic             load;
  logic [1:0]       lane;
  logic [CW-1:0]    step;
  logic [VW-1:0]    rem;
  logic [SW-1:0]    low;
  logic [SW-1:0]    quo;
  logic [VW:0]      trial;
  logic [VW:0]      diff;
  logic             ge;
  dscv_pkg::share_t share_q [dscv_pkg::LANES];

  assign sum = VW'(shares[0]) + VW'(shares[1]) + VW'(shares[2]) + VW'(shares[3]);

  assign trial = {rem, low[SW-1]};
  assign diff  = trial - {1'b0, sum};
  assign ge    = (trial >= {1'b0, sum});

  // sequence lanes and steps
  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy <= 1'b1;
      load <= 1'b1;
      lane <= 2'd0;
      step <= '0;
    end else if (busy) begin
      if (load) begin
        load <= 1'b0;
        step <= '0;
      end else if (step == CW'(SW - 1)) begin
        if (lane == 2'd3) begin
          busy <= 1'b0;
        end else begin
          lane <= lane + 2'd1;
          load <= 1'b1;
        end
      end else begin
        step <= step + CW'(1);
      end
    end
  end

  // divide one bit a cycle
  always_ff @(posedge clk) begin
    if (load) begin
      rem <= VW'(shares[lane] >> 1);
      low <= {shares[lane][0], {(SW-1){1'b0}}};
      quo <= '0;
    end else begin
      rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
      low <= low << 1;
      quo <= {quo[SW-2:0], ge};
      if (busy && step == CW'(SW - 1)) share_q[lane] <= {quo[SW-2:0], ge};
    end
  end

  // drop to fixed shares when the configured sum is about zero
  always_comb begin
    for (int l = 0; l < dscv_pkg::LANES; l++) begin
      cfg_share[l] = (sum <= dscv_pkg::SHARE_SUM_MIN) ? dscv_pkg::FALLBACK_SHARE[l]
                                                     : share_q[l];
    end
  end

endmodule

>>> rtl/dscv_front.sv
// ----------------------------------------------------------------------------
// dscv_front
// Input stage: takes minute words and classifies them against the
// sunrise to sunset window.
// ----------------------------------------------------------------------------
module dscv_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [dscv_pkg::MINUTE_W-1:0] minute_of_day,
  input  logic [dscv_pkg::MINUTE_W-1:0] sunrise,
  input  logic [dscv_pkg::MINUTE_W-1:0] sunset,
  input  logic                          hold,
  input  logic                          slot_full,
  output logic                          full,
  output logic                          slot_push,
  output dscv_pkg::slot_t               slot
);

  logic                          f_valid;
  logic [dscv_pkg::MINUTE_W-1:0] f_minute;
  logic                          accept;
  logic                          in_window;

  assign full      = hold || (f_valid && slot_full);
  assign accept    = push && !full;
  assign slot_push = f_valid && !slot_full;

  // hold the taken minute until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (slot_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) f_minute <= minute_of_day;
  end

  // classify against the window
  assign in_window = (sunset > sunrise) && (f_minute >= sunrise) && (f_minute <= sunset);

  always_comb begin
    slot.daylight = in_window;
    slot.offset   = in_window ? f_minute - sunrise : '0;
    slot.span     = in_window ? sunset - sunrise : dscv_pkg::MINUTE_W'(1);
  end

endmodule

>>> rtl/dscv_back.sv
// ----------------------------------------------------------------------------
// dscv_back
// Computation pipeline: progress divide, sine dome, brightness, channel
// blend and share divide, channel levels.
// ----------------------------------------------------------------------------
module dscv_back #(
  parameter int SINE_TABLE_DEPTH = dscv_pkg::SINE_TABLE_DEPTH,
  parameter int FRACTION_BITS    = dscv_pkg::FRACTION_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  dscv_pkg::slot_t             in_slot,
  input  logic [dscv_pkg::FRAC_W-1:0] peak,
  input  logic [dscv_pkg::FRAC_W-1:0] dimming,
  input  dscv_pkg::share_t            cfg_share [dscv_pkg::LANES],
  output logic                        in_pop,
  output logic                        out_valid,
  output dscv_pkg::result_t           out_res
);

  localparam int FW  = dscv_pkg::FRAC_W;
  localparam int NL  = dscv_pkg::LANES;
  localparam int MW  = dscv_pkg::MINUTE_W;
  localparam int D   = SINE_TABLE_DEPTH;
  localparam int PW  = FRACTION_BITS + 1;
  localparam int PDW = MW + FRACTION_BITS;
  localparam int JW  = $clog2(2 * D + 1);
  localparam int KW  = $clog2(D + 1);
  localparam int XW  = PW + JW + 1;
  localparam int BW  = dscv_pkg::SHARE_W;
  localparam int TW  = BW + 2;
  localparam int SDW = 1 + 2 * FW;
  localparam logic [XW-1:0] TWO_D = XW'(2 * D);
  localparam logic [XW-1:0] HALF  = XW'(1) << (FRACTION_BITS - 1);

  // sine table, built at elaboration
  logic [FW-1:0] sine_tab [D+1];
  for (genvar g = 0; g <= D; g++) begin : g_tab
    localparam logic [63:0] XK = (64'(g) * dscv_pkg::PI_Q30) / 64'(2 * D);
    assign sine_tab[g] = dscv_pkg::sine_q16(XK);
  end

  assign in_pop = in_valid && adv;

  // progress divide
  logic [PDW-1:0] p_dvd [1];
  logic [PW-1:0]  p_quo [1];
  logic           p_valid;
  logic           p_day;

  assign p_dvd[0] = {in_slot.offset, {FRACTION_BITS{1'b0}}};

  dscv_div #(.LANES(1), .DW(PDW), .VW(MW), .QW(PW), .SW(1)) u_pdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (in_valid),
    .dividend (p_dvd),
    .divisor  (in_slot.span),
    .in_side  (in_slot.daylight),
    .out_valid(p_valid),
    .quotient (p_quo),
    .out_side (p_day)
  );

  // table index from progress
  logic [XW-1:0] j_raw;
  logic [JW-1:0] j_idx;
  logic [KW-1:0] k_idx;

  always_comb begin
    j_raw = (XW'(p_quo[0]) * TWO_D + HALF) >> FRACTION_BITS;
    j_idx = (j_raw > TWO_D) ? JW'(2 * D) : j_raw[JW-1:0];
    k_idx = (j_idx <= JW'(D)) ? KW'(j_idx) : KW'(JW'(2 * D) - j_idx);
  end

  logic          a_v, b_v, c_v, d_v, e_v, f_v;
  logic          s_valid;
  logic          a_day, b_day, c_day, d_day, e_day;
  logic [KW-1:0] a_k;
  logic [FW-1:0] b_dome, c_dome, d_dome, e_dome;
  logic [FW-1:0] c_dp, d_bright, e_bright;
  logic [FW-1:0] c_mix [NL];
  logic [BW-1:0] d_blend [NL];
  logic [BW-1:0] e_blend [NL];
  logic [TW-1:0] e_sum;
  logic [FW-1:0] mix_next [NL];
  logic [BW-1:0] blend_next [NL];

  // valid bits advance with the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
      f_v <= 1'b0;
    end else if (adv) begin
      a_v <= p_valid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
      e_v <= d_v;
      f_v <= s_valid;
    end
  end

  // midday mix and blend products
  always_comb begin
    logic [31:0] prod;
    logic [32:0] acc;
    for (int l = 0; l < NL; l++) begin
      prod = 32'(dscv_pkg::MIX_SLOPE[l]) * 32'(b_dome);
      mix_next[l] = dscv_pkg::MIX_FALLS[l] ? dscv_pkg::MIX_BASE[l] - prod[31:16]
                                          : dscv_pkg::MIX_BASE[l] + prod[31:16];
      acc = 33'(32'(dscv_pkg::BLEND_MIX) * 32'(c_mix[l]))
          + 33'(32'(dscv_pkg::BLEND_CFG) * 32'(cfg_share[l]));
      blend_next[l] = acc[32:16];
    end
  end

  // dome, brightness, blend and sum stages
  always_ff @(posedge clk) begin
    logic [31:0] dp;
    logic [31:0] br;
    if (adv) begin
      a_day  <= p_day;
      a_k    <= k_idx;
      b_day  <= a_day;
      b_dome <= a_day ? sine_tab[a_k] : '0;
      dp      = 32'(b_dome) * 32'(peak);
      c_day  <= b_day;
      c_dome <= b_dome;
      c_dp   <= dp[31:16];
      c_mix  <= mix_next;
      br        = 32'(c_dp) * 32'(dimming);
      d_day    <= c_day;
      d_dome   <= c_dome;
      d_bright <= br[31:16];
      d_blend  <= blend_next;
      e_day    <= d_day;
      e_dome   <= d_dome;
      e_bright <= d_bright;
      e_blend  <= d_blend;
      e_sum    <= TW'(d_blend[0]) + TW'(d_blend[1]) + TW'(d_blend[2]) + TW'(d_blend[3]);
    end
  end

  // share divide, four lanes
  logic [BW+FW-1:0] s_dvd [NL];
  logic [BW-1:0]    s_quo [NL];
  logic [SDW-1:0]   s_side;

  always_comb begin
    for (int l = 0; l < NL; l++) s_dvd[l] = {e_blend[l], {FW{1'b0}}};
  end

  dscv_div #(.LANES(NL), .DW(BW + FW), .VW(TW), .QW(BW), .SW(SDW)) u_sdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (e_v),
    .dividend (s_dvd),
    .divisor  (e_sum),
    .in_side  ({e_day, e_dome, e_bright}),
    .out_valid(s_valid),
    .quotient (s_quo),
    .out_side (s_side)
  );

  // channel levels
  logic [FW-1:0] lvl [NL];

  always_comb begin
    logic [FW-1:0] sh;
    logic [31:0]   pr;
    for (int l = 0; l < NL; l++) begin
      sh = (s_quo[l] > BW'(16'hFFFF)) ? 16'hFFFF : s_quo[l][FW-1:0];
      pr = 32'(s_side[FW-1:0]) * 32'(sh);
      lvl[l] = (s_side[2*FW-1:FW] == '0) ? '0 : pr[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res.daylight   <= s_side[SDW-1];
      out_res.dome       <= s_side[2*FW-1:FW];
      out_res.brightness <= s_side[FW-1:0];
      out_res.white      <= lvl[0];
      out_res.blue       <= lvl[1];
      out_res.red        <= lvl[2];
      out_res.far_red    <= lvl[3];
    end
  end

  assign out_valid = f_v;

endmodule

>>> rtl/dscv_checker.sv
// ----------------------------------------------------------------------------
// dscv_checker
// Port-level checks for the daylight spectrum curve block.
// ----------------------------------------------------------------------------
module dscv_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input logic                           daylight,
  input logic [dscv_pkg::FRAC_W-1:0]    dome_level,
  input logic [dscv_pkg::FRAC_W-1:0]    brightness,
  input logic [dscv_pkg::FRAC_W-1:0]    white_level,
  input logic [dscv_pkg::FRAC_W-1:0]    blue_level,
  input logic [dscv_pkg::FRAC_W-1:0]    red_level,
  input logic [dscv_pkg::FRAC_W-1:0]    far_red_level,
  input logic                           cfg_valid,
  input logic                           cfg_ready
);

  // reset leaves no result and holds off input while shares normalize
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && full)
    else $error("block not empty or not holding after reset");

  // a waiting word holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(brightness) && $stable(white_level))
    else $error("result word changed before pop");

  // outside the window every level is zero
  a_dark: assert property (@(posedge clk) disable iff (rst)
    !empty && !daylight |-> dome_level == '0 && brightness == '0 && white_level == '0
      && blue_level == '0 && red_level == '0 && far_red_level == '0)
    else $error("nonzero level outside daylight");

  // brightness never exceeds the dome
  a_bright: assert property (@(posedge clk) disable iff (rst)
    !empty |-> brightness <= dome_level)
    else $error("brightness above dome level");

  // a configuration write holds off input next cycle
  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> full)
    else $error("input taken during share normalization");

endmodule

bind daylight_spectrum_curve_top dscv_checker u_chk (.*);
